FILE: src/clr_pkg.sv
// ============================================================================
// clr_pkg - shared definitions for the clipped line rasterizer
// Register map, configuration record, reset values and sizing helpers.
// ============================================================================
package clr_pkg;

    // Default coordinate width of the endpoint and pixel fields
    localparam int COORD_BITS_DEFAULT = 16;

    // Depth of the command queue between front and engine
    localparam int QUEUE_DEPTH = 2;

    // Fixed field widths
    localparam int CLIP_BITS    = 16;
    localparam int SURF_BITS    = 13;
    localparam int STRIDE_BITS  = 14;
    localparam int ADDR_BITS    = 25;
    localparam int COLOUR_BITS  = 24;
    localparam int WORD_BITS    = 32;

    // APB port sizing
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;

    // Opaque black: alpha forced high, idle results carry this word
    localparam logic [WORD_BITS-1:0] OPAQUE_BLACK = 32'hFF00_0000;
    localparam logic [7:0]           ALPHA_OPAQUE = 8'hFF;

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_CLIP_LEFT      = 3'd0,
        REG_CLIP_TOP       = 3'd1,
        REG_CLIP_RIGHT     = 3'd2,
        REG_CLIP_BOTTOM    = 3'd3,
        REG_SURFACE_WIDTH  = 3'd4,
        REG_SURFACE_HEIGHT = 3'd5,
        REG_ROW_STRIDE     = 3'd6
    } reg_index_t;

    // Configuration record handed from the register block to the engine
    typedef struct packed {
        logic signed [CLIP_BITS-1:0] clip_left;
        logic signed [CLIP_BITS-1:0] clip_top;
        logic signed [CLIP_BITS-1:0] clip_right;
        logic signed [CLIP_BITS-1:0] clip_bottom;
        logic [SURF_BITS-1:0]        surface_width;
        logic [SURF_BITS-1:0]        surface_height;
        logic [STRIDE_BITS-1:0]      row_stride;
    } cfg_t;

    // Reset values of the registers
    localparam logic signed [CLIP_BITS-1:0] CLIP_LEFT_RST   = 16'sd0;
    localparam logic signed [CLIP_BITS-1:0] CLIP_TOP_RST    = 16'sd0;
    localparam logic signed [CLIP_BITS-1:0] CLIP_RIGHT_RST  = 16'sd1;
    localparam logic signed [CLIP_BITS-1:0] CLIP_BOTTOM_RST = 16'sd1;
    localparam logic [SURF_BITS-1:0]        SURF_WIDTH_RST  = 13'd1;
    localparam logic [SURF_BITS-1:0]        SURF_HEIGHT_RST = 13'd1;
    localparam logic [STRIDE_BITS-1:0]      ROW_STRIDE_RST  = 14'd1;

    // Width of one queued command for a given coordinate width:
    // action, zero length, four coordinates, dx, -dy, error, two signs, word
    function automatic int cmd_bits(input int coord);
        return 7 * coord + 42;
    endfunction

endpackage

FILE: src/clr_if.sv
// ============================================================================
// clr_in_if / clr_out_if - valid/ready channels of the line rasterizer
// Draw commands in, pixel transactions out.
// ============================================================================
interface clr_in_if
    import clr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) ();
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COLOUR_BITS-1:0]       line_colour;

    modport source (
        output valid, action, start_x, start_y, end_x, end_y, line_colour,
        input  ready
    );
    modport sink (
        input  valid, action, start_x, start_y, end_x, end_y, line_colour,
        output ready
    );
endinterface

interface clr_out_if
    import clr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [ADDR_BITS-1:0]         pixel_address;
    logic [WORD_BITS-1:0]         pixel_value;
    logic                         write_enable;
    logic                         last_pixel;
    logic                         idle;

    modport source (
        output valid, pixel_x, pixel_y, pixel_address, pixel_value,
               write_enable, last_pixel, idle,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_address, pixel_value,
               write_enable, last_pixel, idle,
        output ready
    );
endinterface

FILE: src/clipped_line_rasterizer.sv
// ============================================================================
// clipped_line_rasterizer - clipped Bresenham line engine
// A command goes through the queue, the line step in stage A and the clip and
// address step in stage B, whose output register holds the result.
// One pixel per clock unless the output stalls; the output register and the
// two-entry command queue let input and output stall independently.
// Reset (rst_n low, asynchronous): queue emptied, no line active, registers
// back to clip 0..1 x 0..1, surface 1 x 1, stride 1.
// ============================================================================
module clipped_line_rasterizer
    import clr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    clr_in_if.sink                   in_port,
    clr_out_if.source                out_port,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int CMD_W = cmd_bits(COORD_BITS);

    cfg_t             cfg;
    logic             q_not_full;
    logic             q_not_empty;
    logic             cmd_push;
    logic             cmd_pop;
    logic [CMD_W-1:0] cmd_in;
    logic [CMD_W-1:0] cmd_out;

    // Configuration registers
    clr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Command front end
    clr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .in_port   (in_port),
        .cmd_ready (q_not_full),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    // Command queue
    clr_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .not_full  (q_not_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .not_empty (q_not_empty)
    );

    // Pixel engine
    clr_engine #(
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (q_not_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .out_port  (out_port)
    );

endmodule

FILE: src/clr_regs.sv
// ============================================================================
// clr_regs - APB configuration registers
// Clip rectangle, surface size and row stride, one register per word.
// ============================================================================
module clr_regs
    import clr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output cfg_t                     cfg
);

    cfg_t       cfg_reg;
    reg_index_t reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_index_t'(paddr[APB_ADDR_BITS-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes, access phase only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clip_left      <= CLIP_LEFT_RST;
            cfg_reg.clip_top       <= CLIP_TOP_RST;
            cfg_reg.clip_right     <= CLIP_RIGHT_RST;
            cfg_reg.clip_bottom    <= CLIP_BOTTOM_RST;
            cfg_reg.surface_width  <= SURF_WIDTH_RST;
            cfg_reg.surface_height <= SURF_HEIGHT_RST;
            cfg_reg.row_stride     <= ROW_STRIDE_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_CLIP_LEFT:      cfg_reg.clip_left      <= pwdata[CLIP_BITS-1:0];
                REG_CLIP_TOP:       cfg_reg.clip_top       <= pwdata[CLIP_BITS-1:0];
                REG_CLIP_RIGHT:     cfg_reg.clip_right     <= pwdata[CLIP_BITS-1:0];
                REG_CLIP_BOTTOM:    cfg_reg.clip_bottom    <= pwdata[CLIP_BITS-1:0];
                REG_SURFACE_WIDTH:  cfg_reg.surface_width  <= pwdata[SURF_BITS-1:0];
                REG_SURFACE_HEIGHT: cfg_reg.surface_height <= pwdata[SURF_BITS-1:0];
                REG_ROW_STRIDE:     cfg_reg.row_stride     <= pwdata[STRIDE_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // Read-back mux
    always_comb
    begin
        case (reg_idx)
            REG_CLIP_LEFT:      prdata = APB_DATA_BITS'($unsigned(cfg_reg.clip_left));
            REG_CLIP_TOP:       prdata = APB_DATA_BITS'($unsigned(cfg_reg.clip_top));
            REG_CLIP_RIGHT:     prdata = APB_DATA_BITS'($unsigned(cfg_reg.clip_right));
            REG_CLIP_BOTTOM:    prdata = APB_DATA_BITS'($unsigned(cfg_reg.clip_bottom));
            REG_SURFACE_WIDTH:  prdata = APB_DATA_BITS'(cfg_reg.surface_width);
            REG_SURFACE_HEIGHT: prdata = APB_DATA_BITS'(cfg_reg.surface_height);
            REG_ROW_STRIDE:     prdata = APB_DATA_BITS'(cfg_reg.row_stride);
            default:            prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/clr_front.sv
// ============================================================================
// clr_front - command front end
// Classifies draw commands and precomputes the Bresenham set-up terms.
// ============================================================================
module clr_front
    import clr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    clr_in_if.sink                         in_port,
    input  logic                           cmd_ready,
    output logic                           cmd_push,
    output logic [cmd_bits(COORD_BITS)-1:0] cmd
);

    localparam int DX_W  = COORD_BITS + 1;
    localparam int NDY_W = COORD_BITS + 2;
    localparam int ERR_W = COORD_BITS + 3;

    typedef struct packed {
        logic                         action;
        logic                         zero_len;
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
        logic signed [COORD_BITS-1:0] tx;
        logic signed [COORD_BITS-1:0] ty;
        logic signed [DX_W-1:0]       dx;
        logic signed [NDY_W-1:0]      ndy;
        logic signed [ERR_W-1:0]      err;
        logic                         sxn;
        logic                         syn;
        logic [WORD_BITS-1:0]         word;
    } cmd_t;

    cmd_t                   cmd_s;
    logic signed [DX_W-1:0] diff_x;
    logic signed [DX_W-1:0] diff_y;
    logic signed [DX_W-1:0] abs_x;
    logic signed [DX_W-1:0] abs_y;

    // Handshake: take a transaction whenever the queue has room
    assign in_port.ready = cmd_ready;
    assign cmd_push      = in_port.valid && cmd_ready;

    // Absolute deltas
    assign diff_x = DX_W'(in_port.end_x) - DX_W'(in_port.start_x);
    assign diff_y = DX_W'(in_port.end_y) - DX_W'(in_port.start_y);
    assign abs_x  = diff_x[DX_W-1] ? -diff_x : diff_x;
    assign abs_y  = diff_y[DX_W-1] ? -diff_y : diff_y;

    // Command record
    always_comb
    begin
        cmd_s.action   = in_port.action;
        cmd_s.zero_len = (in_port.start_x == in_port.end_x) &&
                         (in_port.start_y == in_port.end_y);
        cmd_s.sx       = in_port.start_x;
        cmd_s.sy       = in_port.start_y;
        cmd_s.tx       = in_port.end_x;
        cmd_s.ty       = in_port.end_y;
        cmd_s.dx       = abs_x;
        cmd_s.ndy      = -NDY_W'(abs_y);
        cmd_s.err      = ERR_W'(abs_x) - ERR_W'(abs_y);
        cmd_s.sxn      = !(in_port.start_x < in_port.end_x);
        cmd_s.syn      = !(in_port.start_y < in_port.end_y);
        // BGR in, opaque ARGB out: swap red and blue bytes
        cmd_s.word     = {ALPHA_OPAQUE, in_port.line_colour[7:0],
                          in_port.line_colour[15:8], in_port.line_colour[23:16]};
    end

    assign cmd = cmd_s;

endmodule

FILE: src/clr_queue.sv
// ============================================================================
// clr_queue - short command FIFO
// Decouples the front end from the pixel engine.
// ============================================================================
module clr_queue
    import clr_pkg::*;
#(
    parameter int WIDTH = cmd_bits(COORD_BITS_DEFAULT),
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             not_full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: src/clr_engine.sv
// ============================================================================
// clr_engine - Bresenham pixel engine
// Stage A steps the line state; stage B clips, forms the address and
// holds the output transaction.
// ============================================================================
module clr_engine
    import clr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cfg_t                            cfg,
    input  logic                            cmd_valid,
    input  logic [cmd_bits(COORD_BITS)-1:0] cmd,
    output logic                            cmd_pop,
    clr_out_if.source                       out_port
);

    localparam int DX_W  = COORD_BITS + 1;
    localparam int NDY_W = COORD_BITS + 2;
    localparam int ERR_W = COORD_BITS + 3;
    localparam int E2_W  = ERR_W + 1;
    localparam int CMP_W = ((COORD_BITS > CLIP_BITS) ? COORD_BITS : CLIP_BITS) + 1;
    localparam int PROD_W = SURF_BITS + STRIDE_BITS;

    typedef struct packed {
        logic                         action;
        logic                         zero_len;
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
        logic signed [COORD_BITS-1:0] tx;
        logic signed [COORD_BITS-1:0] ty;
        logic signed [DX_W-1:0]       dx;
        logic signed [NDY_W-1:0]      ndy;
        logic signed [ERR_W-1:0]      err;
        logic                         sxn;
        logic                         syn;
        logic [WORD_BITS-1:0]         word;
    } cmd_t;

    cmd_t c;

    // Line state (stage A)
    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0] tgt_x_reg;
    logic signed [COORD_BITS-1:0] tgt_y_reg;
    logic signed [DX_W-1:0]       dx_reg;
    logic signed [NDY_W-1:0]      ndy_reg;
    logic signed [ERR_W-1:0]      err_reg, err_next;
    logic                         sxn_reg;
    logic                         syn_reg;
    logic [WORD_BITS-1:0]         word_reg;
    logic                         active_reg;
    logic                         a_valid_reg;
    logic                         a_last_reg;
    logic                         a_idle_reg;

    // Output register (stage B)
    logic                         out_valid_reg;
    logic signed [COORD_BITS-1:0] out_x_reg;
    logic signed [COORD_BITS-1:0] out_y_reg;
    logic [ADDR_BITS-1:0]         out_addr_reg;
    logic [WORD_BITS-1:0]         out_word_reg;
    logic                         out_we_reg;
    logic                         out_last_reg;
    logic                         out_idle_reg;

    logic                         a_ready;
    logic                         b_ready;
    logic signed [E2_W-1:0]       e2;
    logic                         move_x;
    logic                         move_y;
    logic                         step_last;

    logic signed [CMP_W-1:0]      x_w;
    logic signed [CMP_W-1:0]      y_w;
    logic                         in_clip;
    logic                         we;
    logic [PROD_W-1:0]            prod;
    logic [PROD_W:0]              addr_sum;

    assign c = cmd;

    // Flow control: each stage advances when the one after it has room
    assign b_ready = !out_valid_reg || out_port.ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign cmd_pop = cmd_valid && a_ready;

    // One Bresenham step from the current state
    assign e2     = {err_reg, 1'b0};
    assign move_x = (e2 >= E2_W'(ndy_reg));
    assign move_y = (e2 <= E2_W'(dx_reg));

    always_comb
    begin
        err_next   = err_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        if (move_x)
        begin
            err_next   = err_next + ERR_W'(ndy_reg);
            cur_x_next = sxn_reg ? cur_x_reg - COORD_BITS'(1) : cur_x_reg + COORD_BITS'(1);
        end
        if (move_y)
        begin
            err_next   = err_next + ERR_W'(dx_reg);
            cur_y_next = syn_reg ? cur_y_reg - COORD_BITS'(1) : cur_y_reg + COORD_BITS'(1);
        end
    end

    assign step_last = (cur_x_next == tgt_x_reg) && (cur_y_next == tgt_y_reg);

    // Stage A: line state and emitted pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            tgt_x_reg   <= '0;
            tgt_y_reg   <= '0;
            dx_reg      <= '0;
            ndy_reg     <= '0;
            err_reg     <= '0;
            sxn_reg     <= 1'b0;
            syn_reg     <= 1'b0;
            word_reg    <= OPAQUE_BLACK;
            active_reg  <= 1'b0;
            a_valid_reg <= 1'b0;
            a_last_reg  <= 1'b0;
            a_idle_reg  <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= cmd_pop;
            if (cmd_pop)
            begin
                if (!c.action)
                begin
                    // New line: load endpoints, first pixel is the start point
                    cur_x_reg  <= c.sx;
                    cur_y_reg  <= c.sy;
                    tgt_x_reg  <= c.tx;
                    tgt_y_reg  <= c.ty;
                    dx_reg     <= c.dx;
                    ndy_reg    <= c.ndy;
                    err_reg    <= c.err;
                    sxn_reg    <= c.sxn;
                    syn_reg    <= c.syn;
                    word_reg   <= c.word;
                    active_reg <= !c.zero_len;
                    a_last_reg <= c.zero_len;
                    a_idle_reg <= 1'b0;
                end
                else if (!active_reg)
                begin
                    // Step with no line in progress
                    a_last_reg <= 1'b0;
                    a_idle_reg <= 1'b1;
                end
                else
                begin
                    cur_x_reg  <= cur_x_next;
                    cur_y_reg  <= cur_y_next;
                    err_reg    <= err_next;
                    active_reg <= !step_last;
                    a_last_reg <= step_last;
                    a_idle_reg <= 1'b0;
                end
            end
        end
    end

    // Clip test against the rectangle and the surface
    assign x_w = CMP_W'(cur_x_reg);
    assign y_w = CMP_W'(cur_y_reg);

    assign in_clip = (x_w >= CMP_W'(cfg.clip_left))  && (y_w >= CMP_W'(cfg.clip_top))   &&
                     (x_w <  CMP_W'(cfg.clip_right)) && (y_w <  CMP_W'(cfg.clip_bottom)) &&
                     !x_w[CMP_W-1] && !y_w[CMP_W-1] &&
                     (x_w < $signed(CMP_W'(cfg.surface_width))) &&
                     (y_w < $signed(CMP_W'(cfg.surface_height)));
    assign we = in_clip && !a_idle_reg;

    // Frame-buffer address; row and column are below the surface size here
    assign prod     = y_w[SURF_BITS-1:0] * cfg.row_stride;
    assign addr_sum = (PROD_W + 1)'(prod) + (PROD_W + 1)'(x_w[SURF_BITS-1:0]);

    // Stage B: output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            out_x_reg    <= a_idle_reg ? '0 : cur_x_reg;
            out_y_reg    <= a_idle_reg ? '0 : cur_y_reg;
            out_addr_reg <= we ? addr_sum[ADDR_BITS-1:0] : '0;
            out_word_reg <= a_idle_reg ? OPAQUE_BLACK : word_reg;
            out_we_reg   <= we;
            out_last_reg <= a_last_reg;
            out_idle_reg <= a_idle_reg;
        end
    end

    assign out_port.valid         = out_valid_reg;
    assign out_port.pixel_x       = out_x_reg;
    assign out_port.pixel_y       = out_y_reg;
    assign out_port.pixel_address = out_addr_reg;
    assign out_port.pixel_value   = out_word_reg;
    assign out_port.write_enable  = out_we_reg;
    assign out_port.last_pixel    = out_last_reg;
    assign out_port.idle          = out_idle_reg;

    // An idle transaction never writes the frame buffer
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_idle_reg |-> !out_we_reg)
        else $error("idle transaction with write enable");

    // A start command always yields a live, non-idle pixel
    a_start_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && !c.action |=> a_valid_reg && !a_idle_reg)
        else $error("start command produced an idle pixel");

    // A step with no line in progress gives an idle pixel and keeps the engine idle
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && c.action && !active_reg |=> a_idle_reg && !active_reg)
        else $error("idle step mishandled");

    // Once the end point is emitted the line is closed
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && a_last_reg |-> !active_reg)
        else $error("line still active after its last pixel");

endmodule
